FILE: src/hkrgbw_pkg.sv
// ----------------------------------------------------------------------------
// hkrgbw_pkg
// Shared types and constants of the hue knob to RGBW fade block.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrgbw_pkg;

  localparam int unsigned KNOB_W      = 10;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned ELAPSED_W   = 17;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 8'd255;
  localparam logic [LEVEL_W-1:0] THRESH_RESET  = 8'd128;

  // APB register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [0:0]  REG_FADE_STEP_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [KNOB_W-1:0] hue_knob;
    logic [KNOB_W-1:0] color_lightness_knob;
    logic [KNOB_W-1:0] white_lightness_knob;
    logic              fade_key;
  } in_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] white_level;
  } out_word_t;

  // Undimmed levels plus the key, handed from front to back
  typedef struct packed {
    out_word_t levels;
    logic      fade_key;
  } mid_word_t;

endpackage

`default_nettype wire

FILE: src/hkrgbw_front.sv
// ----------------------------------------------------------------------------
// hkrgbw_front
// Accept a knob word, map the hue onto the color wheel and scale by lightness.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrgbw_front
  import hkrgbw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           mid_valid_o,
  input  wire logic      mid_ready_i,
  output mid_word_t      mid_data_o
);

  typedef enum logic [2:0] {
    SEC_RED_GREEN_UP   = 3'd0,
    SEC_GREEN_RED_DOWN = 3'd1,
    SEC_BLUE_UP        = 3'd2,
    SEC_GREEN_DOWN     = 3'd3,
    SEC_RED_UP         = 3'd4,
    SEC_BLUE_DOWN      = 3'd5
  } sector_e;

  logic [KNOB_W+1:0]  hue_x3;
  logic [KNOB_W:0]    hue_scaled;
  logic [LEVEL_W-1:0] ramp;
  logic [LEVEL_W-1:0] wheel_r, wheel_g, wheel_b;
  logic [LEVEL_W-1:0] light;
  logic [2*LEVEL_W-1:0] prod_r, prod_g, prod_b;
  mid_word_t          mid_d, mid_q;
  logic               valid_q;
  logic               take;

  // hue * 3 / 2 as shift-add
  assign hue_x3     = {2'b00, in_data_i.hue_knob} + {1'b0, in_data_i.hue_knob, 1'b0};
  assign hue_scaled = hue_x3[KNOB_W+1:1];
  assign ramp       = hue_scaled[LEVEL_W-1:0];

  always_comb begin
    case (sector_e'(hue_scaled[KNOB_W:LEVEL_W]))
      SEC_RED_GREEN_UP: begin
        wheel_r = LEVEL_MAX; wheel_g = ramp; wheel_b = '0;
      end
      SEC_GREEN_RED_DOWN: begin
        wheel_r = LEVEL_MAX - ramp; wheel_g = LEVEL_MAX; wheel_b = '0;
      end
      SEC_BLUE_UP: begin
        wheel_r = '0; wheel_g = LEVEL_MAX; wheel_b = ramp;
      end
      SEC_GREEN_DOWN: begin
        wheel_r = '0; wheel_g = LEVEL_MAX - ramp; wheel_b = LEVEL_MAX;
      end
      SEC_RED_UP: begin
        wheel_r = ramp; wheel_g = '0; wheel_b = LEVEL_MAX;
      end
      default: begin
        wheel_r = LEVEL_MAX; wheel_g = '0; wheel_b = LEVEL_MAX - ramp;
      end
    endcase
  end

  assign light  = in_data_i.color_lightness_knob[KNOB_W-1:2];
  assign prod_r = wheel_r * light;
  assign prod_g = wheel_g * light;
  assign prod_b = wheel_b * light;

  always_comb begin
    mid_d.levels.red_level   = prod_r[2*LEVEL_W-1:LEVEL_W];
    mid_d.levels.green_level = prod_g[2*LEVEL_W-1:LEVEL_W];
    mid_d.levels.blue_level  = prod_b[2*LEVEL_W-1:LEVEL_W];
    mid_d.levels.white_level = in_data_i.white_lightness_knob[KNOB_W-1:2];
    mid_d.fade_key           = in_data_i.fade_key;
  end

  assign in_ready_o = !valid_q || mid_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = valid_q;
  assign mid_data_o  = mid_q;

endmodule

`default_nettype wire

FILE: src/hkrgbw_queue.sv
// ----------------------------------------------------------------------------
// hkrgbw_queue
// Short first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrgbw_queue
  import hkrgbw_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire mid_word_t  push_data_i,
  output logic            pop_valid_o,
  input  wire logic       pop_ready_i,
  output mid_word_t       pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mid_word_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/hkrgbw_back.sv
// ----------------------------------------------------------------------------
// hkrgbw_back
// Run the fade timer in order and dim the levels into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrgbw_back
  import hkrgbw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [LEVEL_W-1:0] threshold_i,
  input  wire logic               mid_valid_i,
  output logic                    mid_ready_o,
  input  wire mid_word_t          mid_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_word_t               out_data_o
);

  logic                  active_q, active_d;
  logic [LEVEL_W-1:0]    bright_q, bright_d;
  logic [ELAPSED_W-1:0]  elapsed_q, elapsed_d;
  logic                  out_valid_q;
  out_word_t             out_q, out_d;
  logic                  pop;
  logic [LEVEL_W-1:0]    bright_cur;
  logic [ELAPSED_W-1:0]  elapsed_cur;
  logic [LEVEL_W-1:0]    discount;

  function automatic logic [LEVEL_W-1:0] dim(input logic [LEVEL_W-1:0] x,
                                             input logic [LEVEL_W-1:0] d);
    dim = (x > d) ? x - d : '0;
  endfunction

  assign mid_ready_o = !out_valid_q || out_ready_i;
  assign pop         = mid_valid_i && mid_ready_o;

  always_comb begin
    active_d    = active_q || mid_data_i.fade_key;
    bright_cur  = mid_data_i.fade_key ? LEVEL_MAX : bright_q;
    elapsed_cur = mid_data_i.fade_key ? '0 : elapsed_q;
    bright_d    = bright_cur;
    elapsed_d   = elapsed_cur;
    out_d       = mid_data_i.levels;
    discount    = '0;
    if (active_d) begin
      if (bright_cur == '0) begin
        out_d = '0;
      end else begin
        // step down once elapsed / 256 passes the threshold
        if (elapsed_cur[ELAPSED_W-1:LEVEL_W] > {1'b0, threshold_i}) begin
          elapsed_d = '0;
          bright_d  = bright_cur - 1'b1;
        end else begin
          elapsed_d = elapsed_cur + ELAPSED_W'(bright_cur);
        end
        discount          = ~bright_d;
        out_d.red_level   = dim(mid_data_i.levels.red_level, discount);
        out_d.green_level = dim(mid_data_i.levels.green_level, discount);
        out_d.blue_level  = dim(mid_data_i.levels.blue_level, discount);
        out_d.white_level = dim(mid_data_i.levels.white_level, discount);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      bright_q    <= '0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mid_ready_o) begin
        out_valid_q <= mid_valid_i;
      end
      if (pop) begin
        active_q  <= active_d;
        bright_q  <= bright_d;
        elapsed_q <= elapsed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/hue_knob_to_rgbw_with_fade_top.sv
// ----------------------------------------------------------------------------
// hue_knob_to_rgbw_with_fade_top
// Hue and lightness knob words to red, green, blue, white levels with fade.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one knob
//   word per handshake; output channel (out_valid_o / out_ready_i /
//   out_data_o) returns exactly one level word per input word, in order.
//   The APB port holds one register, fade_step_threshold, at address 0;
//   write it only while no word is in flight.
// Pipeline and throughput:
//   A taken input word passes the front register, the queue and the output
//   register, in that order, before its result shows on out_valid_o. One
//   word per cycle is sustained while out_ready_i stays high; the path front
//   register -> queue -> output register sets that rate, and the fade timer update in the back stage adds no stall.
// Reset:
//   Clears all handshake state and the fade timer (fade idle, levels
//   undimmed) and loads the threshold with 128.
// Stalls:
//   When the receiver holds out_ready_i low, the output register keeps its
//   word, the queue fills, and in_ready_o drops only once front register and
//   queue are both full; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hue_knob_to_rgbw_with_fade_top
  import hkrgbw_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input words
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_word_t              in_data_i,
  // result words
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_word_t                  out_data_o,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [LEVEL_W-1:0] threshold_q;
  logic               cfg_write;
  logic               mid_valid, mid_ready;
  mid_word_t          mid_data;
  logic               q_valid, q_ready;
  mid_word_t          q_data;

  // Register file: byte address 4*i selects register i
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESH_RESET;
    end else if (cfg_write && (paddr[APB_ADDR_W-1:2] == REG_FADE_STEP_THRESHOLD)) begin
      threshold_q <= pwdata[LEVEL_W-1:0];
    end
  end

  // Read back the threshold; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_FADE_STEP_THRESHOLD) begin
      prdata = APB_DATA_W'(threshold_q);
    end
  end

  // Front: accept word, compute undimmed wheel levels
  hkrgbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_data_o  (mid_data)
  );

  // Queue: decouple front from back so each side stalls on its own
  hkrgbw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (mid_valid),
    .push_ready_o (mid_ready),
    .push_data_i  (mid_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // Back: advance the fade timer and dim into the output register
  hkrgbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .mid_valid_i (q_valid),
    .mid_ready_o (q_ready),
    .mid_data_i  (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
